// ===== rtl/core/v4a_pkg.sv =====
// Shared types and constants for the Q16.16 four-element vector unit.
// Used by the front end, the decoded-item queue, the back end and the top level.
package v4a_pkg;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPW      = $clog2(QDEPTH);
  localparam int unsigned QCW      = QPW + 1;
  localparam int unsigned LANES    = 4;
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 48;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_SCALE = 3'd3,
    OP_DIV   = 3'd4,
    OP_MAG   = 3'd5,
    OP_NORM  = 3'd6,
    OP_DOT   = 3'd7
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] a;
    logic [3:0][31:0] b;
    logic [31:0]      sc;
    logic             w_one;
    logic             w_zero;
    logic             sc_zero;
  } item_t;

  typedef struct packed {
    logic [3:0][31:0] r;
    logic [31:0]      so;
    logic             w_one;
    logic             w_zero;
    logic             err;
  } result_t;

endpackage

// ===== rtl/core/vec4_arith_unit.sv =====
// Four-element Q16.16 vector unit: add, sub, negate, scale, divide, magnitude,
// normalize and dot, with saturation. An accepted item passes the front register,
// the queue, the multiply and combine stages, 32 square-root stages, divider setup,
// 48 divider stages and the result register before its result appears.
// Throughput is one item per cycle; a stalled result holds the whole back pipeline.
// Synchronous active-low reset empties all stages and the queue; no other state.
module vec4_arith_unit import v4a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_a_w,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_b_w,
  input  logic [31:0] in_scalar,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_r_x,
  output logic [31:0] out_r_y,
  output logic [31:0] out_r_z,
  output logic [31:0] out_r_w,
  output logic [31:0] out_scalar_out,
  output logic        out_a_is_point,
  output logic        out_a_is_vector,
  output logic        out_error
);

  item_t   fq_data;
  logic    fq_push;
  logic    fq_full;
  item_t   bq_data;
  logic    bq_pop;
  logic    bq_empty;
  result_t res;

  v4a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_a_w       (in_a_w),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .in_b_w       (in_b_w),
    .in_scalar    (in_scalar),
    .q_push       (fq_push),
    .q_data       (fq_data),
    .q_full       (fq_full)
  );

  v4a_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_push  (fq_push),
    .wr_data  (fq_data),
    .wr_full  (fq_full),
    .rd_pop   (bq_pop),
    .rd_data  (bq_data),
    .rd_empty (bq_empty)
  );

  v4a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (bq_data),
    .q_empty   (bq_empty),
    .q_pop     (bq_pop),
    .out_data  (res),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign out_r_x         = res.r[0];
  assign out_r_y         = res.r[1];
  assign out_r_z         = res.r[2];
  assign out_r_w         = res.r[3];
  assign out_scalar_out  = res.so;
  assign out_a_is_point  = res.w_one;
  assign out_a_is_vector = res.w_zero;
  assign out_error       = res.err;

  // The front end must never hand an item to a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> !fq_full)
    else $error("item pushed into full queue");

  // An error result carries zeros in every value field.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error) |-> (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 &&
                               out_r_w == '0 && out_scalar_out == '0))
    else $error("error result with nonzero fields");

  // w cannot equal both one and zero.
  a_point_vector: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_a_is_point && out_a_is_vector))
    else $error("point and vector flags both set");

endmodule

// ===== rtl/core/v4a_fifo.sv =====
// Short queue of decoded items between the front end and the back end.
// Depends on v4a_pkg for item_t and the queue depth.
module v4a_fifo import v4a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_push,
  input  item_t wr_data,
  output logic  wr_full,
  input  logic  rd_pop,
  output item_t rd_data,
  output logic  rd_empty
);

  item_t            mem_r [0:QDEPTH-1];
  logic [QPW-1:0]   wp_r;
  logic [QPW-1:0]   rp_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_full  = (cnt_r == QCW'(QDEPTH));
  assign rd_empty = (cnt_r == '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_push && !wr_full;
  assign do_rd    = rd_pop && !rd_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== rtl/core/v4a_front.sv =====
// Front end: takes an input item, classifies it and hands it to the queue.
// Depends on v4a_pkg for item_t, op_t and the Q16.16 constants.
module v4a_front import v4a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_a_w,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_b_w,
  input  logic [31:0] in_scalar,
  output logic        q_push,
  output item_t       q_data,
  input  logic        q_full
);

  item_t it_r;
  item_t it_nxt;
  logic  vld_r;
  logic  take;

  assign full   = vld_r && q_full;
  assign take   = push && !full;
  assign q_push = vld_r && !q_full;
  assign q_data = it_r;

  always_comb begin
    it_nxt         = '0;
    it_nxt.op      = op_t'(in_operation);
    it_nxt.a       = {in_a_w, in_a_z, in_a_y, in_a_x};
    it_nxt.b       = {in_b_w, in_b_z, in_b_y, in_b_x};
    it_nxt.sc      = in_scalar;
    it_nxt.w_one   = (in_a_w == Q_ONE);
    it_nxt.w_zero  = (in_a_w == '0);
    it_nxt.sc_zero = (in_scalar == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (q_push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) it_r <= it_nxt;
  end

endmodule

// ===== rtl/core/v4a_back.sv =====
// Back end: multiply stage, combine stage, pipelined square root and
// pipelined four-lane divider, then the result register. Depends on v4a_pkg.
module v4a_back import v4a_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   q_data,
  input  logic    q_empty,
  output logic    q_pop,
  output result_t out_data,
  output logic    out_empty,
  input  logic    out_pop
);

  typedef struct packed {
    op_t              op;
    logic [3:0]       neg;
    logic [3:0][31:0] mag;
    logic             den_neg;
    logic [31:0]      den;
    logic [31:0]      a_w;
    logic [3:0][31:0] res;
    logic [31:0]      so;
    logic             err;
    logic             w_one;
    logic             w_zero;
  } ctl_t;

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return S32_MAX;
    if (v < -66'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  logic adv;
  logic ov_r;
  result_t od_r;

  // The whole pipeline moves together whenever the result register can take a value.
  assign adv       = !ov_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !ov_r;
  assign out_data  = od_r;

  // Multiply stage.
  logic               s1_v_r;
  item_t              s1_it_r;
  logic signed [63:0] s1_p_r [0:LANES-1];
  logic signed [63:0] prod   [0:LANES-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [31:0] m2;
      unique case (q_data.op)
        OP_SCALE: m2 = q_data.sc;
        OP_DOT:   m2 = q_data.b[i];
        default:  m2 = q_data.a[i];
      endcase
      prod[i] = $signed(q_data.a[i]) * $signed(m2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it_r <= q_data;
      for (int i = 0; i < LANES; i++) s1_p_r[i] <= prod[i];
    end
  end

  // Combine stage: the simple operations finish here.
  ctl_t        c2;
  logic [63:0] sumsq;

  always_comb begin
    logic signed [32:0] s33;
    logic signed [63:0] sh;
    logic signed [65:0] dsum;
    logic signed [65:0] dsh;
    c2         = '0;
    c2.op      = s1_it_r.op;
    c2.a_w     = s1_it_r.a[3];
    c2.w_one   = s1_it_r.w_one;
    c2.w_zero  = s1_it_r.w_zero;
    c2.den_neg = s1_it_r.sc[31];
    c2.den     = s1_it_r.sc[31] ? (32'd0 - s1_it_r.sc) : s1_it_r.sc;
    for (int i = 0; i < LANES; i++) begin
      c2.neg[i] = s1_it_r.a[i][31];
      c2.mag[i] = s1_it_r.a[i][31] ? (32'd0 - s1_it_r.a[i]) : s1_it_r.a[i];
    end
    dsum = {{2{s1_p_r[0][63]}}, s1_p_r[0]} + {{2{s1_p_r[1][63]}}, s1_p_r[1]}
         + {{2{s1_p_r[2][63]}}, s1_p_r[2]};
    dsh  = dsum >>> 16;
    sumsq = 64'(s1_p_r[0]) + 64'(s1_p_r[1]) + 64'(s1_p_r[2]);
    for (int i = 0; i < LANES; i++) begin
      s33 = '0;
      sh  = s1_p_r[i] >>> 16;
      unique case (s1_it_r.op)
        OP_ADD: begin
          s33 = $signed({s1_it_r.a[i][31], s1_it_r.a[i]})
              + $signed({s1_it_r.b[i][31], s1_it_r.b[i]});
          c2.res[i] = sat66({{33{s33[32]}}, s33});
        end
        OP_SUB: begin
          s33 = $signed({s1_it_r.a[i][31], s1_it_r.a[i]})
              - $signed({s1_it_r.b[i][31], s1_it_r.b[i]});
          c2.res[i] = sat66({{33{s33[32]}}, s33});
        end
        OP_NEG: begin
          c2.res[i] = (s1_it_r.a[i] == S32_MIN) ? S32_MAX : (32'd0 - s1_it_r.a[i]);
        end
        OP_SCALE: begin
          c2.res[i] = sat66({{2{sh[63]}}, sh});
        end
        default: begin
          c2.res[i] = '0;
        end
      endcase
    end
    unique case (s1_it_r.op)
      OP_DOT:  c2.so = sat66(dsh);
      OP_DIV:  c2.err = s1_it_r.sc_zero;
      default: c2.so = '0;
    endcase
  end

  // Square root: one result bit per stage.
  logic        sq_v_r    [0:SQ_STEPS];
  ctl_t        sq_c_r    [0:SQ_STEPS];
  logic [34:0] sq_rem_r  [0:SQ_STEPS];
  logic [31:0] sq_root_r [0:SQ_STEPS];
  logic [63:0] sq_rad_r  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c_r[0]    <= c2;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= sumsq;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [34:0] cur;
    logic [34:0] trial;
    logic        ge;

    always_comb begin
      cur   = {sq_rem_r[k][32:0], sq_rad_r[k][63:62]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (adv) sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c_r[k+1]    <= sq_c_r[k];
        sq_rem_r[k+1]  <= ge ? (cur - trial) : cur;
        sq_root_r[k+1] <= {sq_root_r[k][30:0], ge};
        sq_rad_r[k+1]  <= {sq_rad_r[k][61:0], 2'b00};
      end
    end
  end

  // Divider setup: normalize divides by the magnitude, divide by |scalar|.
  ctl_t        c3;
  logic [31:0] mroot;

  always_comb begin
    mroot = sq_root_r[SQ_STEPS];
    c3    = sq_c_r[SQ_STEPS];
    unique case (c3.op)
      OP_NORM: begin
        c3.den     = mroot;
        c3.den_neg = 1'b0;
        c3.err     = (mroot == '0);
      end
      OP_MAG: begin
        c3.so = mroot[31] ? S32_MAX : mroot;
      end
      default: begin
        c3.den = c3.den;
      end
    endcase
  end

  // Restoring divider: one quotient bit per stage in every lane.
  logic        dv_v_r   [0:DV_STEPS];
  ctl_t        dv_c_r   [0:DV_STEPS];
  logic [47:0] dv_num_r [0:DV_STEPS][0:LANES-1];
  logic [31:0] dv_rem_r [0:DV_STEPS][0:LANES-1];
  logic [47:0] dv_q_r   [0:DV_STEPS][0:LANES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= sq_v_r[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c_r[0] <= c3;
      for (int j = 0; j < LANES; j++) begin
        dv_num_r[0][j] <= {c3.mag[j], 16'h0000};
        dv_rem_r[0][j] <= '0;
        dv_q_r[0][j]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
    logic [32:0] cur [0:LANES-1];
    logic        ge  [0:LANES-1];

    always_comb begin
      for (int j = 0; j < LANES; j++) begin
        cur[j] = {dv_rem_r[k][j], dv_num_r[k][j][47]};
        ge[j]  = (cur[j] >= {1'b0, dv_c_r[k].den});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (adv) dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c_r[k+1] <= dv_c_r[k];
        for (int j = 0; j < LANES; j++) begin
          dv_num_r[k+1][j] <= {dv_num_r[k][j][46:0], 1'b0};
          dv_rem_r[k+1][j] <= ge[j] ? 32'(cur[j] - {1'b0, dv_c_r[k].den}) : cur[j][31:0];
          dv_q_r[k+1][j]   <= {dv_q_r[k][j][46:0], ge[j]};
        end
      end
    end
  end

  // Sign fix, saturation and final selection.
  result_t fin;

  always_comb begin
    ctl_t               cf;
    logic [31:0]        dq [0:LANES-1];
    logic signed [65:0] qs;
    cf = dv_c_r[DV_STEPS];
    for (int j = 0; j < LANES; j++) begin
      qs = $signed({18'b0, dv_q_r[DV_STEPS][j]});
      if (cf.neg[j] ^ cf.den_neg) qs = -qs;
      dq[j] = sat66(qs);
    end
    fin        = '0;
    fin.so     = cf.so;
    fin.err    = cf.err;
    fin.w_one  = cf.w_one;
    fin.w_zero = cf.w_zero;
    unique case (cf.op)
      OP_DIV: begin
        if (!cf.err) fin.r = {dq[3], dq[2], dq[1], dq[0]};
      end
      OP_NORM: begin
        if (!cf.err) fin.r = {cf.a_w, dq[2], dq[1], dq[0]};
      end
      default: begin
        fin.r = cf.res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= dv_v_r[DV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) od_r <= fin;
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for vec4_arith_unit, the Q16.16 four-element vector unit.
// Predicts each result from the item fields and checks every output field in order.
// Depends on v4a_pkg and the vec4_arith_unit RTL.
`timescale 1ns / 1ps

class vec_result_board;
  typedef struct {
    logic [31:0] r [4];
    logic [31:0] so;
    logic        pt;
    logic        vc;
    logic        err;
  } vres_t;

  vres_t pending[$];
  int    fails;

  function new();
    fails = 0;
  endfunction

  static function longint sat(longint v);
    longint res;
    res = v;
    if (v > 64'sd2147483647) res = 64'sd2147483647;
    if (v < -64'sd2147483648) res = -64'sd2147483648;
    return res;
  endfunction

  // Floor division by 65536; an arithmetic shift does exactly that.
  static function longint floor16(longint v);
    longint res;
    res = v >>> 16;
    return res;
  endfunction

  static function longint unsigned root64(longint unsigned num);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function void note_item(v4a_pkg::op_t op, logic [31:0] a [4], logic [31:0] b [4],
                          logic [31:0] sc);
    vres_t e;
    longint av [4];
    longint bv [4];
    longint s, qsum, rsum, p, q;
    longint unsigned sq, m;
    for (int i = 0; i < 4; i++) begin
      av[i] = longint'(signed'(a[i]));
      bv[i] = longint'(signed'(b[i]));
      e.r[i] = '0;
    end
    s = longint'(signed'(sc));
    e.so = '0;
    e.err = 1'b0;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(av[i] * av[i]);
    m = root64(sq);
    case (op)
      v4a_pkg::OP_ADD: for (int i = 0; i < 4; i++) e.r[i] = 32'(sat(av[i] + bv[i]));
      v4a_pkg::OP_SUB: for (int i = 0; i < 4; i++) e.r[i] = 32'(sat(av[i] - bv[i]));
      v4a_pkg::OP_NEG: for (int i = 0; i < 4; i++) e.r[i] = 32'(sat(-av[i]));
      v4a_pkg::OP_SCALE:
        for (int i = 0; i < 4; i++) e.r[i] = 32'(sat(floor16(av[i] * s)));
      v4a_pkg::OP_DIV: begin
        if (s == 0) e.err = 1'b1;
        else for (int i = 0; i < 4; i++) e.r[i] = 32'(sat((av[i] * 65536) / s));
      end
      v4a_pkg::OP_MAG: e.so = (m > 64'd2147483647) ? 32'h7fff_ffff : m[31:0];
      v4a_pkg::OP_NORM: begin
        if (m == 0) e.err = 1'b1;
        else begin
          for (int i = 0; i < 3; i++)
            e.r[i] = 32'(sat((av[i] * 65536) / longint'(m)));
          e.r[3] = a[3];
        end
      end
      default: begin
        qsum = 0;
        rsum = 0;
        for (int i = 0; i < 3; i++) begin
          p = av[i] * bv[i];
          q = floor16(p);
          qsum += q;
          rsum += p - q * 65536;
        end
        e.so = 32'(sat(qsum + floor16(rsum)));
      end
    endcase
    e.pt = (a[3] == v4a_pkg::Q_ONE);
    e.vc = (a[3] == 32'd0);
    pending.push_back(e);
  endfunction

  function void check_result(logic [31:0] r [4], logic [31:0] so, logic pt, logic vc,
                             logic err);
    vres_t e;
    if (pending.size() == 0) begin
      $error("result arrived with no item outstanding");
      fails++;
      return;
    end
    e = pending.pop_front();
    for (int i = 0; i < 4; i++)
      if (r[i] !== e.r[i]) begin
        $error("r[%0d]: expected %h, got %h", i, e.r[i], r[i]);
        fails++;
      end
    if (so !== e.so) begin
      $error("scalar_out: expected %h, got %h", e.so, so);
      fails++;
    end
    if (pt !== e.pt) begin
      $error("a_is_point: expected %b, got %b", e.pt, pt);
      fails++;
    end
    if (vc !== e.vc) begin
      $error("a_is_vector: expected %b, got %b", e.vc, vc);
      fails++;
    end
    if (err !== e.err) begin
      $error("error: expected %b, got %b", e.err, err);
      fails++;
    end
  endfunction
endclass

module tb;
  import v4a_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic [31:0] in_scalar = '0;
  logic [31:0] out_r_x, out_r_y, out_r_z, out_r_w, out_scalar_out;
  logic        out_a_is_point, out_a_is_vector, out_error;

  vec_result_board board = new();
  int send_idle = 0;
  int take_idle = 0;
  bit hold_off = 1'b0;

  vec4_arith_unit uut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'd0;
      3: v = Q_ONE;
      4: v = -Q_ONE;
      5, 6: v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      7: v = 32'($signed($urandom_range(0, 4095)) - 2048) <<< 16;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Presents one item and holds it until the block takes it.
  task automatic send_item(op_t op, logic [31:0] a [4], logic [31:0] b [4],
                           logic [31:0] sc);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    {in_a_x, in_a_y, in_a_z, in_a_w} <= {a[0], a[1], a[2], a[3]};
    {in_b_x, in_b_y, in_b_z, in_b_w} <= {b[0], b[1], b[2], b[3]};
    in_scalar <= sc;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_item(op, a, b, sc);
  endtask

  task automatic send_random();
    logic [31:0] a [4];
    logic [31:0] b [4];
    for (int i = 0; i < 4; i++) begin
      a[i] = pick_value();
      b[i] = pick_value();
    end
    if ($urandom_range(0, 3) == 0) a[3] = ($urandom_range(0, 1) == 1) ? Q_ONE : 32'd0;
    send_item(op_t'($urandom_range(0, 7)), a, b, pick_value());
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: pop under random stall, checking at each accepted edge.
  always @(posedge clk) begin
    logic [31:0] rr [4];
    if (rst_n && pop && !empty) begin
      rr = '{out_r_x, out_r_y, out_r_z, out_r_w};
      board.check_result(rr, out_scalar_out, out_a_is_point, out_a_is_vector, out_error);
    end
    pop <= !hold_off && ($urandom_range(0, 99) >= take_idle);
  end

  initial begin
    logic [31:0] a [4];
    logic [31:0] b [4];
    logic [31:0] corner [6];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, Q_ONE, 32'hffff_ffff, 32'h0003_0000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation on corner values, plus the error cases.
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = corner[(k + i) % 6];
        b[i] = corner[(k + 2 * i + 1) % 6];
      end
      send_item(op_t'(k % 8), a, b, corner[(k + 3) % 6]);
    end
    a = '{32'd0, 32'd0, 32'd0, Q_ONE};
    b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0};
    send_item(OP_NORM, a, b, 32'd0);
    send_item(OP_DIV, a, b, 32'd0);
    a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0};
    send_item(OP_MAG, a, b, 32'd0);
    send_item(OP_DOT, a, b, 32'd0);
    send_item(OP_NORM, a, b, 32'd0);
    send_item(OP_SCALE, a, b, 32'h8000_0000);
    send_item(OP_DIV, a, b, 32'h0000_0001);
    send_item(OP_NEG, a, b, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 57 : 18) : 0;
      take_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 57 : 18) : 0;
      repeat (225) send_random();
    end
    send_idle = 0;
    take_idle = 0;

    // Fill the block while the result side holds off, then let everything out.
    // More items are offered than the pipeline and queue can hold, so the
    // input stalls and the last item is taken only after the release.
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (150) send_random();
    join
    drain();
    repeat (40) send_random();

    drain();
    repeat (100) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== vec4_arith_unit.f =====
rtl/core/v4a_pkg.sv
rtl/core/v4a_fifo.sv
rtl/core/v4a_front.sv
rtl/core/v4a_back.sv
rtl/core/vec4_arith_unit.sv
test/tb.sv
